FILE: rtl/core/bpbg_pkg.sv
`default_nettype none

package bpbg_pkg;

  // Widest counter/target index supported by default.
  localparam int unsigned MAX_INDEX_BITS_DEF = 10;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register map, word index into the configuration space.
  typedef enum logic [1:0] {
    REG_INDEX_BITS   = 2'd0,
    REG_HISTORY_BITS = 2'd1,
    REG_INDEX_MODE   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_BIMODAL = 1'b0,
    MODE_GSELECT = 1'b1
  } index_mode_e;

  localparam logic [3:0] INDEX_BITS_RST   = 4'd10;
  localparam logic [3:0] HISTORY_BITS_RST = 4'd0;

  // Counter reset value: weakly not taken.
  localparam logic [1:0] CNT_RST = 2'b01;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } state_e;

  typedef struct packed {
    logic [3:0]  index_bits;
    logic [3:0]  history_bits;
    index_mode_e index_mode;
  } cfg_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/branch_predictor_bimodal_gselect_btb_unit.sv
// Branch predictor with 2-bit direction counters (bimodal or gselect index)
// and a direct-mapped target buffer. Each request carries a resolved branch
// (its PC and actual next PC); the response is the prediction made from the
// tables before that branch updates them: the buffered target when the
// counter is 2 or 3, otherwise PC+4. A request first does a registered read
// of the counter and target memories, then updates them and loads the
// output register. One request is in flight at a time: a new request is not
// taken until the last has done the read-then-write of the tables. A result
// held in the output register does not stop the next request from being
// taken; that request then waits in its update cycle until the slot drains.
// After reset a clearing pass writes all 2^MAX_INDEX_BITS entries (1024 at
// the default) of each table with in_ready_o low; configuration writes are
// taken throughout. Registers at byte offsets 0, 4, 8: index_bits,
// history_bits, index_mode; write them only when idle.
`default_nettype none

module branch_predictor_bimodal_gselect_btb_unit
  import bpbg_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [63:0]           branch_pc_i,
  input  wire logic [63:0]           actual_next_pc_i,
  // Response channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [63:0]           predicted_pc_o,
  output logic                       predicted_taken_o,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Register file: sizes and index mode.
  bpbg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: clearing pass, capture, commit, handshakes.
  bpbg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tables, history and the output register.
  bpbg_dp #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .branch_pc_i       (branch_pc_i),
    .actual_next_pc_i  (actual_next_pc_i),
    .predicted_pc_o    (predicted_pc_o),
    .predicted_taken_o (predicted_taken_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bpbg_ram.sv
`default_nettype none

module bpbg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bpbg_cfg.sv
`default_nettype none

module bpbg_cfg
  import bpbg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_INDEX_BITS:   cfg_d.index_bits   = pwdata[3:0];
        REG_HISTORY_BITS: cfg_d.history_bits = pwdata[3:0];
        REG_INDEX_MODE:   cfg_d.index_mode   = index_mode_e'(pwdata[0]);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INDEX_BITS:   prdata = {28'd0, cfg_q.index_bits};
      REG_HISTORY_BITS: prdata = {28'd0, cfg_q.history_bits};
      REG_INDEX_MODE:   prdata = {31'd0, cfg_q.index_mode};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.index_bits   <= INDEX_BITS_RST;
      cfg_q.history_bits <= HISTORY_BITS_RST;
      cfg_q.index_mode   <= MODE_BIMODAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/bpbg_ctrl.sv
`default_nettype none

module bpbg_ctrl
  import bpbg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  status_t      status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output slot can take a new result when empty or being drained now.
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.commit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/bpbg_dp.sv
`default_nettype none

module bpbg_dp
  import bpbg_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  wire logic [63:0] branch_pc_i,
  input  wire logic [63:0] actual_next_pc_i,
  output logic      [63:0] predicted_pc_o,
  output logic             predicted_taken_o
);

  localparam int unsigned M     = MAX_INDEX_BITS;
  localparam int unsigned SW    = $clog2(M + 1);
  localparam int unsigned DEPTH = 1 << M;

  function automatic logic [M-1:0] low_mask(input logic [SW-1:0] n);
    logic [M:0] t;
    t = ({{M{1'b0}}, 1'b1} << n) - {{M{1'b0}}, 1'b1};
    return t[M-1:0];
  endfunction

  logic [SW-1:0] s_w, h_w;
  logic [M-1:0]  hist_q, hist_d, hist_m, hmask;
  logic [M-1:0]  pc_field, bidx_w, cidx_w;
  logic [M-1:0]  bidx_q, cidx_q, clr_cnt_q;
  logic [63:0]   pc_q, next_q, fall, btb_rdata;
  logic [1:0]    cnt_rdata, cnt_new;
  logic          taken, pred_taken;

  // Effective index and history lengths.
  always_comb begin
    if (cfg_i.index_bits == 4'd0) begin
      s_w = SW'(1);
    end else if (32'(cfg_i.index_bits) > 32'(M)) begin
      s_w = SW'(M);
    end else begin
      s_w = SW'(cfg_i.index_bits);
    end
    if (32'(cfg_i.history_bits) > 32'(s_w)) begin
      h_w = s_w;
    end else begin
      h_w = SW'(cfg_i.history_bits);
    end
  end

  assign hmask    = low_mask(h_w);
  assign hist_m   = hist_q & hmask;
  assign pc_field = branch_pc_i[3 +: M];
  assign bidx_w   = pc_field & low_mask(s_w);

  always_comb begin
    if (cfg_i.index_mode == MODE_GSELECT) begin
      cidx_w = ((pc_field & low_mask(s_w - h_w)) << h_w) | hist_m;
    end else begin
      cidx_w = bidx_w;
    end
  end

  // Resolve the held request against the table contents.
  assign fall       = pc_q + 64'd4;
  assign taken      = next_q != fall;
  assign pred_taken = cnt_rdata[1];

  always_comb begin
    cnt_new = cnt_rdata;
    if (taken) begin
      if (cnt_rdata != 2'b11) cnt_new = cnt_rdata + 2'b01;
    end else begin
      if (cnt_rdata != 2'b00) cnt_new = cnt_rdata - 2'b01;
    end
  end

  assign hist_d = ((hist_m << 1) | {{(M-1){1'b0}}, taken}) & hmask;

  bpbg_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_en | cmd_i.commit),
    .waddr_i (cmd_i.clear_en ? clr_cnt_q : cidx_q),
    .wdata_i (cmd_i.clear_en ? CNT_RST : cnt_new),
    .re_i    (cmd_i.capture),
    .raddr_i (cidx_w),
    .rdata_o (cnt_rdata)
  );

  bpbg_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_btb_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_en | (cmd_i.commit & taken)),
    .waddr_i (cmd_i.clear_en ? clr_cnt_q : bidx_q),
    .wdata_i (cmd_i.clear_en ? 64'd0 : next_q),
    .re_i    (cmd_i.capture),
    .raddr_i (bidx_w),
    .rdata_o (btb_rdata)
  );

  assign status_o.clear_done = &clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      hist_q    <= '0;
    end else begin
      if (cmd_i.clear_en) clr_cnt_q <= clr_cnt_q + {{(M-1){1'b0}}, 1'b1};
      if (cmd_i.commit)   hist_q    <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pc_q   <= branch_pc_i;
      next_q <= actual_next_pc_i;
      bidx_q <= bidx_w;
      cidx_q <= cidx_w;
    end
    if (cmd_i.commit) begin
      predicted_pc_o    <= pred_taken ? btb_rdata : fall;
      predicted_taken_o <= pred_taken;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bpbg_checker.sv
`default_nettype none

module bpbg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] predicted_pc_o,
  input wire logic        predicted_taken_o
);

  // Tables are still being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request taken during clearing pass");

  // One request in flight: no new request the cycle after one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  // A new response only appears after an update cycle with ready low.
  a_resp_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response without a preceding update");

  // A stalled response holds.
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(predicted_pc_o) && $stable(predicted_taken_o)))
    else $error("stalled response changed");

endmodule

bind branch_predictor_bimodal_gselect_btb_unit bpbg_checker u_bpbg_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .predicted_pc_o    (predicted_pc_o),
  .predicted_taken_o (predicted_taken_o)
);

`default_nettype wire
